### rtl/core/prsd_pkg.sv
`default_nettype none

package prsd_pkg;

   localparam int unsigned STORE_BYTES   = 64000;
   localparam int unsigned PITCH_W       = 11;
   localparam logic [10:0] PITCH_RESET   = 11'd320;
   localparam logic [7:0]  RECORD_MARKER = 8'h10;
   localparam logic [15:0] PLANE_END     = 16'h8000;
   localparam logic [3:0]  STYLE_SPANS   = 4'd15;
   localparam logic [1:0]  LAST_PLANE    = 2'd3;

   typedef enum logic [3:0] {
      PH_MARKER = 4'd0,
      PH_FORMAT = 4'd1,
      PH_MINX   = 4'd2,
      PH_MINY   = 4'd3,
      PH_MAXX   = 4'd4,
      PH_MAXY   = 4'd5,
      PH_Y      = 4'd6,
      PH_X      = 4'd7,
      PH_CNT    = 4'd8,
      PH_LEN    = 4'd9,
      PH_FILL   = 4'd10,
      PH_LIT    = 4'd11,
      PH_DONE   = 4'd12
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL    = 2'd0,
      KIND_FILL     = 2'd1,
      KIND_FINISHED = 2'd2,
      KIND_ERROR    = 2'd3
   } kind_type;

endpackage

`default_nettype wire

### rtl/core/planar_rle_span_decoder_core.sv
// Run-length span decoder for one planar picture record.
// The request channel carries one record byte per item, with req_record_start
// marking the first byte of a record; that byte clears the parser and must be
// the marker. Each accepted item yields zero or one result item on the
// response channel: a single pixel write, a fill run with its length and
// address step, a record-finished notice or a format error.
// A result is registered and presented in the cycle after its item is
// accepted, and the block accepts one item in every cycle unless req_stall
// is high: the parser update and the address computation (one 16 by 11 bit
// multiply plus adds) sit between the parser state and the result register.
// When the receiver stalls, the result register holds its item, and the
// request channel is stalled only while that register is full and stalled.
// The user must write the row pitch register through csr_wr_en and
// csr_wr_data only while the block is idle; the block does not enforce it.
// Reset is synchronous: it empties the result register, sets the row pitch
// to 320 and returns the parser to waiting for a record marker.
`default_nettype none

module planar_rle_span_decoder_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [7:0]                     req_stream_byte,
   input  wire logic                           req_record_start,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      prsd_pkg::kind_type             rsp_result_kind,
   output      logic [15:0]                    rsp_pixel_address,
   output      logic [7:0]                     rsp_pixel_value,
   output      logic [15:0]                    rsp_run_length,
   output      logic [2:0]                     rsp_address_step,
   output      logic                           rsp_outside_store,
   input  wire logic                           csr_wr_en,
   input  wire logic [prsd_pkg::PITCH_W-1:0]   csr_wr_data
);
   import prsd_pkg::*;

   logic [PITCH_W-1:0] pitch_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  low_hold_ff, low_hold_in;
   logic        four_plane_ff, four_plane_in;
   logic [1:0]  plane_ff, plane_in;
   logic [15:0] xoff_ff, xoff_in;
   logic [15:0] yoff_ff, yoff_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] runs_ff, runs_in;
   logic [15:0] lits_ff, lits_in;
   logic        half_ff, half_in;
   logic        style_ok_ff, style_ok_in;

   logic        rsp_valid_ff;
   kind_type    kind_ff, kind_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  value_ff, value_in;
   logic [15:0] len_ff, len_in;
   logic [2:0]  step_ff, step_in;
   logic        outside_ff, outside_in;
   logic        emit_in;

   logic        accept;
   logic [26:0] row_prod;
   logic [15:0] cur_row, cur_col, word, runs_dec, lits_dec;
   logic [1:0]  cur_plane;
   logic        cur_four;
   logic [15:0] pix_addr;
   logic [2:0]  cur_step;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign cur_row   = req_record_start ? 16'd0 : row_ff;
   assign cur_col   = req_record_start ? 16'd0 : col_ff;
   assign cur_plane = req_record_start ? 2'd0 : plane_ff;
   assign cur_four  = req_record_start ? 1'b0 : four_plane_ff;
   assign cur_step  = cur_four ? 3'd4 : 3'd1;
   assign row_prod  = {11'd0, cur_row} * {16'd0, pitch_ff};
   assign pix_addr  = (cur_four ? {cur_col[13:0], 2'b00} : cur_col)
                      + {14'd0, cur_plane} + row_prod[15:0];
   assign word      = {req_stream_byte, low_hold_ff};
   assign runs_dec  = runs_ff - 16'd1;
   assign lits_dec  = lits_ff - 16'd1;

   always_comb begin
      phase_in      = phase_ff;
      low_hold_in   = low_hold_ff;
      four_plane_in = four_plane_ff;
      plane_in      = plane_ff;
      xoff_in       = xoff_ff;
      yoff_in       = yoff_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      runs_in       = runs_ff;
      lits_in       = lits_ff;
      half_in       = half_ff;
      style_ok_in   = style_ok_ff;
      if (req_record_start) begin
         phase_in      = PH_MARKER;
         low_hold_in   = 8'd0;
         four_plane_in = 1'b0;
         plane_in      = 2'd0;
         xoff_in       = 16'd0;
         yoff_in       = 16'd0;
         row_in        = 16'd0;
         col_in        = 16'd0;
         runs_in       = 16'd0;
         lits_in       = 16'd0;
         half_in       = 1'b0;
         style_ok_in   = 1'b0;
      end

      emit_in    = 1'b0;
      kind_in    = KIND_PIXEL;
      addr_in    = 16'd0;
      value_in   = 8'd0;
      len_in     = 16'd0;
      step_in    = 3'd0;
      outside_in = 1'b0;

      unique case (phase_in)
         PH_MARKER: begin
            if (req_stream_byte != RECORD_MARKER) begin
               phase_in = PH_DONE;
               emit_in  = 1'b1;
               kind_in  = KIND_ERROR;
            end else begin
               phase_in = PH_FORMAT;
            end
         end
         PH_FORMAT: begin
            style_ok_in   = req_stream_byte[3:0] == STYLE_SPANS;
            four_plane_in = req_stream_byte[4];
            plane_in      = 2'd0;
            phase_in      = PH_MINX;
         end
         PH_FILL: begin
            emit_in    = 1'b1;
            kind_in    = KIND_FILL;
            addr_in    = pix_addr;
            value_in   = req_stream_byte;
            len_in     = lits_ff;
            step_in    = cur_step;
            outside_in = {1'b0, pix_addr} >= 17'(STORE_BYTES);
            col_in     = col_ff + lits_ff;
            lits_in    = 16'd0;
            runs_in    = runs_dec;
            phase_in   = (runs_dec != 16'd0) ? PH_LEN : PH_Y;
         end
         PH_LIT: begin
            emit_in    = 1'b1;
            kind_in    = KIND_PIXEL;
            addr_in    = pix_addr;
            value_in   = req_stream_byte;
            len_in     = 16'd1;
            step_in    = cur_step;
            outside_in = {1'b0, pix_addr} >= 17'(STORE_BYTES);
            col_in     = col_ff + 16'd1;
            lits_in    = lits_dec;
            if (lits_dec == 16'd0) begin
               runs_in  = runs_dec;
               phase_in = (runs_dec != 16'd0) ? PH_LEN : PH_Y;
            end
         end
         PH_DONE: begin
         end
         PH_MINX, PH_MINY, PH_MAXX, PH_MAXY, PH_Y, PH_X, PH_CNT, PH_LEN: begin
            if (!half_in) begin
               low_hold_in = req_stream_byte;
               half_in     = 1'b1;
            end else begin
               half_in = 1'b0;
               unique case (phase_in)
                  PH_MINX: begin
                     xoff_in  = 16'd0 - word;
                     phase_in = PH_MINY;
                  end
                  PH_MINY: begin
                     yoff_in  = 16'd0 - word;
                     phase_in = PH_MAXX;
                  end
                  PH_MAXX: begin
                     phase_in = PH_MAXY;
                  end
                  PH_MAXY: begin
                     if (!style_ok_ff) begin
                        phase_in = PH_DONE;
                        emit_in  = 1'b1;
                        kind_in  = KIND_FINISHED;
                     end else begin
                        phase_in = PH_Y;
                     end
                  end
                  PH_Y: begin
                     if (word == PLANE_END) begin
                        if (four_plane_ff && plane_ff != LAST_PLANE) begin
                           plane_in = plane_ff + 2'd1;
                        end else begin
                           phase_in = PH_DONE;
                           emit_in  = 1'b1;
                           kind_in  = KIND_FINISHED;
                        end
                     end else begin
                        row_in   = word + yoff_ff;
                        phase_in = PH_X;
                     end
                  end
                  PH_X: begin
                     col_in   = word + xoff_ff;
                     phase_in = PH_CNT;
                  end
                  PH_CNT: begin
                     if (word[15]) begin
                        runs_in = 16'd1;
                        if (word[7]) begin
                           lits_in  = 16'd256 - {8'd0, word[7:0]};
                           phase_in = PH_FILL;
                        end else if (word[7:0] == 8'd0) begin
                           runs_in  = 16'd0;
                           phase_in = PH_Y;
                        end else begin
                           lits_in  = {8'd0, word[7:0]};
                           phase_in = PH_LIT;
                        end
                     end else begin
                        runs_in  = word;
                        phase_in = (word != 16'd0) ? PH_LEN : PH_Y;
                     end
                  end
                  default: begin
                     if (word[15]) begin
                        lits_in  = 16'd0 - word;
                        phase_in = PH_FILL;
                     end else if (word == 16'd0) begin
                        runs_in  = runs_dec;
                        phase_in = (runs_dec != 16'd0) ? PH_LEN : PH_Y;
                     end else begin
                        lits_in  = word;
                        phase_in = PH_LIT;
                     end
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff      <= PITCH_RESET;
         phase_ff      <= PH_MARKER;
         low_hold_ff   <= 8'd0;
         four_plane_ff <= 1'b0;
         plane_ff      <= 2'd0;
         xoff_ff       <= 16'd0;
         yoff_ff       <= 16'd0;
         row_ff        <= 16'd0;
         col_ff        <= 16'd0;
         runs_ff       <= 16'd0;
         lits_ff       <= 16'd0;
         half_ff       <= 1'b0;
         style_ok_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pitch_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff      <= phase_in;
            low_hold_ff   <= low_hold_in;
            four_plane_ff <= four_plane_in;
            plane_ff      <= plane_in;
            xoff_ff       <= xoff_in;
            yoff_ff       <= yoff_in;
            row_ff        <= row_in;
            col_ff        <= col_in;
            runs_ff       <= runs_in;
            lits_ff       <= lits_in;
            half_ff       <= half_in;
            style_ok_ff   <= style_ok_in;
            rsp_valid_ff  <= emit_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit_in) begin
         kind_ff    <= kind_in;
         addr_ff    <= addr_in;
         value_ff   <= value_in;
         len_ff     <= len_in;
         step_ff    <= step_in;
         outside_ff <= outside_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_value   = value_ff;
   assign rsp_run_length    = len_ff;
   assign rsp_address_step  = step_ff;
   assign rsp_outside_store = outside_ff;

endmodule

`default_nettype wire

### verif/span_decode_checker.sv
`timescale 1ns / 100ps

module span_decode_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [7:0]                    req_stream_byte,
   input  logic                          req_record_start,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  prsd_pkg::kind_type            rsp_result_kind,
   input  logic [15:0]                   rsp_pixel_address,
   input  logic [7:0]                    rsp_pixel_value,
   input  logic [15:0]                   rsp_run_length,
   input  logic [2:0]                    rsp_address_step,
   input  logic                          rsp_outside_store,
   input  logic                          csr_wr_en,
   input  logic [prsd_pkg::PITCH_W-1:0]  csr_wr_data,
   output int                            mismatch_count,
   output int                            expected_left,
   output int                            bytes_accepted,
   output int                            results_checked,
   output int                            fills_checked
);
   import prsd_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  value;
      logic [15:0] length;
      logic [2:0]  step;
      logic        outside;
   } span_result_type;

   span_result_type expected_spans[$];

   logic [PITCH_W-1:0] pitch;
   phase_type          phase;
   logic [7:0]         low_hold;
   logic               four_planes;
   logic [1:0]         plane;
   logic [15:0]        x_shift;
   logic [15:0]        y_shift;
   logic [15:0]        row;
   logic [15:0]        column;
   logic [15:0]        runs_left;
   logic [15:0]        pixels_left;
   logic               high_half;
   logic               style_ok;

   function void clear_parser();
      phase = PH_MARKER;
      low_hold = '0;
      four_planes = 1'b0;
      plane = '0;
      x_shift = '0;
      y_shift = '0;
      row = '0;
      column = '0;
      runs_left = '0;
      pixels_left = '0;
      high_half = 1'b0;
      style_ok = 1'b0;
   endfunction

   function automatic string describe(span_result_type r);
      return $sformatf("kind %0d addr %h value %h len %0d step %0d out %b",
                       r.kind, r.address, r.value, r.length, r.step, r.outside);
   endfunction

   function automatic span_result_type place_pixel(kind_type kind, logic [7:0] value,
                                                   logic [15:0] length);
      span_result_type r;
      logic [2:0] step;
      logic [31:0] sum;
      step = four_planes ? 3'd4 : 3'd1;
      sum = 32'(column) * 32'(step) + 32'(plane) + 32'(row) * 32'(pitch);
      r.kind = kind;
      r.address = sum[15:0];
      r.value = value;
      r.length = length;
      r.step = step;
      r.outside = (32'(sum[15:0]) >= STORE_BYTES);
      return r;
   endfunction

   function void close_run();
      runs_left = runs_left - 16'd1;
      phase = (runs_left != 0) ? PH_LEN : PH_Y;
   endfunction

   function automatic bit decode_stream_byte(logic [7:0] b, logic first,
                                             output span_result_type r);
      logic [15:0] w;
      bit emitted;
      emitted = 1'b0;
      r = '0;
      if (first) begin
         clear_parser();
      end
      case (phase)
         PH_MARKER: begin
            if (b != RECORD_MARKER) begin
               phase = PH_DONE;
               r.kind = KIND_ERROR;
               emitted = 1'b1;
            end else begin
               phase = PH_FORMAT;
            end
         end
         PH_FORMAT: begin
            style_ok = (b[3:0] == STYLE_SPANS);
            four_planes = b[4];
            plane = '0;
            phase = PH_MINX;
         end
         PH_FILL: begin
            r = place_pixel(KIND_FILL, b, pixels_left);
            emitted = 1'b1;
            column = column + pixels_left;
            pixels_left = '0;
            close_run();
         end
         PH_LIT: begin
            r = place_pixel(KIND_PIXEL, b, 16'd1);
            emitted = 1'b1;
            column = column + 16'd1;
            pixels_left = pixels_left - 16'd1;
            if (pixels_left == 0) begin
               close_run();
            end
         end
         PH_DONE: begin
         end
         default: begin
            if (!high_half) begin
               low_hold = b;
               high_half = 1'b1;
            end else begin
               high_half = 1'b0;
               w = {b, low_hold};
               case (phase)
                  PH_MINX: begin
                     x_shift = 16'd0 - w;
                     phase = PH_MINY;
                  end
                  PH_MINY: begin
                     y_shift = 16'd0 - w;
                     phase = PH_MAXX;
                  end
                  PH_MAXX: begin
                     phase = PH_MAXY;
                  end
                  PH_MAXY: begin
                     if (!style_ok) begin
                        phase = PH_DONE;
                        r.kind = KIND_FINISHED;
                        emitted = 1'b1;
                     end else begin
                        phase = PH_Y;
                     end
                  end
                  PH_Y: begin
                     if (w == PLANE_END) begin
                        if (four_planes && plane != LAST_PLANE) begin
                           plane = plane + 2'd1;
                        end else begin
                           phase = PH_DONE;
                           r.kind = KIND_FINISHED;
                           emitted = 1'b1;
                        end
                     end else begin
                        row = w + y_shift;
                        phase = PH_X;
                     end
                  end
                  PH_X: begin
                     column = w + x_shift;
                     phase = PH_CNT;
                  end
                  PH_CNT: begin
                     if (w[15]) begin
                        runs_left = 16'd1;
                        if (w[7]) begin
                           pixels_left = 16'd256 - {8'd0, w[7:0]};
                           phase = PH_FILL;
                        end else if (w[7:0] == 0) begin
                           runs_left = '0;
                           phase = PH_Y;
                        end else begin
                           pixels_left = {8'd0, w[7:0]};
                           phase = PH_LIT;
                        end
                     end else begin
                        runs_left = w;
                        phase = (w != 0) ? PH_LEN : PH_Y;
                     end
                  end
                  PH_LEN: begin
                     if (w[15]) begin
                        pixels_left = 16'd0 - w;
                        phase = PH_FILL;
                     end else if (w == 0) begin
                        close_run();
                     end else begin
                        pixels_left = w;
                        phase = PH_LIT;
                     end
                  end
                  default: begin
                     phase = PH_DONE;
                  end
               endcase
            end
         end
      endcase
      return emitted;
   endfunction

   always @(posedge clock) begin
      span_result_type want;
      span_result_type got;
      if (reset) begin
         pitch = PITCH_RESET;
         clear_parser();
         expected_spans.delete();
         mismatch_count = 0;
         bytes_accepted = 0;
         results_checked = 0;
         fills_checked = 0;
      end else begin
         if (csr_wr_en) begin
            pitch = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            bytes_accepted++;
            if (decode_stream_byte(req_stream_byte, req_record_start, want)) begin
               expected_spans.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_result_kind;
            got.address = rsp_pixel_address;
            got.value = rsp_pixel_value;
            got.length = rsp_run_length;
            got.step = rsp_address_step;
            got.outside = rsp_outside_store;
            results_checked++;
            if (got.kind == KIND_FILL) begin
               fills_checked++;
            end
            if (expected_spans.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected result item: kind %0d addr %h value %h",
                           $realtime, got.kind, got.address, got.value);
               end
               mismatch_count++;
            end else begin
               want = expected_spans.pop_front();
               if (got != want) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: result %0d expected %s", $realtime, results_checked,
                              describe(want));
                     $display("%0t: result %0d actual   %s", $realtime, results_checked,
                              describe(got));
                  end
                  mismatch_count++;
               end
            end
         end
      end
      expected_left = expected_spans.size();
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import prsd_pkg::*;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_stream_byte = '0;
   logic               req_record_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   kind_type           rsp_result_kind;
   logic [15:0]        rsp_pixel_address;
   logic [7:0]         rsp_pixel_value;
   logic [15:0]        rsp_run_length;
   logic [2:0]         rsp_address_step;
   logic               rsp_outside_store;
   logic               csr_wr_en = 1'b0;
   logic [PITCH_W-1:0] csr_wr_data = '0;

   int mismatch_count;
   int expected_left;
   int bytes_accepted;
   int results_checked;
   int fills_checked;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   logic [8:0] byte_stream[$];

   planar_rle_span_decoder_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .req_record_start  (req_record_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_run_length    (rsp_run_length),
      .rsp_address_step  (rsp_address_step),
      .rsp_outside_store (rsp_outside_store),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   span_decode_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .req_record_start  (req_record_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_run_length    (rsp_run_length),
      .rsp_address_step  (rsp_address_step),
      .rsp_outside_store (rsp_outside_store),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .expected_left     (expected_left),
      .bytes_accepted    (bytes_accepted),
      .results_checked   (results_checked),
      .fills_checked     (fills_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver stalls at random, or for a long stretch when one is requested.
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      #1000000;
      $display("planar_rle_span_decoder_core verification failed");
      $finish;
   end

   function void put_byte(logic [7:0] b, logic first);
      byte_stream.push_back({first, b});
   endfunction

   function void put_word(logic [15:0] w);
      put_byte(w[7:0], 1'b0);
      put_byte(w[15:8], 1'b0);
   endfunction

   function automatic logic [15:0] pick_coord();
      if ($urandom_range(0, 9) < 7) begin
         return 16'($urandom_range(0, 400));
      end
      return 16'($urandom);
   endfunction

   function automatic void add_picture_record();
      int pick;
      int start_at;
      int n;
      logic quad;
      logic [3:0] style;
      logic [7:0] lead;
      logic [15:0] w;
      pick = $urandom_range(0, 99);
      start_at = byte_stream.size();
      if (pick < 5) begin
         repeat ($urandom_range(1, 6)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
         return;
      end
      if (pick < 10) begin
         lead = 8'($urandom);
         if (lead == RECORD_MARKER) begin
            lead[0] = ~lead[0];
         end
         put_byte(lead, 1'b1);
         repeat ($urandom_range(0, 4)) put_byte(8'($urandom), 1'b0);
         return;
      end
      quad = 1'($urandom_range(0, 1));
      style = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 14)) : STYLE_SPANS;
      put_byte(RECORD_MARKER, 1'b1);
      put_byte({3'($urandom), quad, style}, 1'b0);
      repeat (4) put_word(pick_coord());
      if (style == STYLE_SPANS) begin
         repeat (quad ? 4 : 1) begin
            repeat ($urandom_range(0, 3)) begin
               w = pick_coord();
               put_word((w == PLANE_END) ? 16'd0 : w);
               put_word(pick_coord());
               if ($urandom_range(0, 9) < 3) begin
                  case ($urandom_range(0, 2))
                     0: begin
                        n = $urandom_range(1, 128);
                        put_word({1'b1, 7'($urandom), 8'(256 - n)});
                        put_byte(8'($urandom), 1'b0);
                     end
                     1: begin
                        n = ($urandom_range(0, 19) == 0) ? 127 : $urandom_range(1, 6);
                        put_word({1'b1, 7'($urandom), 8'(n)});
                        repeat (n) put_byte(8'($urandom), 1'b0);
                     end
                     default: begin
                        put_word({1'b1, 7'($urandom), 8'd0});
                     end
                  endcase
               end else begin
                  n = $urandom_range(0, 3);
                  put_word(16'(n));
                  repeat (n) begin
                     case ($urandom_range(0, 4))
                        0, 1: begin
                           case ($urandom_range(0, 9))
                              0: n = 32768;
                              1: n = $urandom_range(1, 32768);
                              default: n = $urandom_range(1, 40);
                           endcase
                           put_word(16'(32'h10000 - n));
                           put_byte(8'($urandom), 1'b0);
                        end
                        2, 3: begin
                           n = $urandom_range(1, 6);
                           put_word(16'(n));
                           repeat (n) put_byte(8'($urandom), 1'b0);
                        end
                        default: begin
                           put_word(16'd0);
                        end
                     endcase
                  end
               end
            end
            put_word(PLANE_END);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
      end
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, byte_stream.size() - start_at - 1)) begin
            void'(byte_stream.pop_back());
         end
      end
   endfunction

   task automatic offer_byte(logic [7:0] b, logic first);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= b;
      req_record_start <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_quiet();
      int guard;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (expected_left != 0 && guard < 20000);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_row_pitch(logic [PITCH_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_stream(int segment);
      int total;
      total = byte_stream.size();
      for (int k = 0; k < total; k++) begin
         if (segment == 0 && k == total / 2) begin
            hold_requests <= hold_requests + 1;
         end
         if (segment == 1 && k == total / 2) begin
            req_valid <= 1'b0;
            wait_quiet();
         end
         offer_byte(byte_stream[k][7:0], byte_stream[k][8]);
      end
      req_valid <= 1'b0;
      byte_stream.delete();
   endtask

   initial begin
      logic [PITCH_W-1:0] pitches[5];
      pitches[0] = 11'd1;
      pitches[1] = 11'd1024;
      pitches[2] = 11'd0;
      pitches[3] = 11'd2047;
      pitches[4] = 11'($urandom_range(1, 1024));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A bad marker, then a single-plane record with a wrapped column,
      // a short-count fill of 128 and a full-length fill of 32768.
      put_byte(8'hFF, 1'b1);
      put_byte(RECORD_MARKER, 1'b1);
      put_byte(8'h0F, 1'b0);
      put_word(16'h0000);
      put_word(16'h0000);
      put_word(16'hFFFF);
      put_word(16'hFFFF);
      put_word(16'h0000);
      put_word(16'hFFFF);
      put_word(16'h8080);
      put_byte(8'hFF, 1'b0);
      put_word(16'h0001);
      put_word(16'h0000);
      put_word(16'h0001);
      put_word(16'h8000);
      put_byte(8'h00, 1'b0);
      put_word(PLANE_END);
      send_stream(-1);
      wait_quiet();

      for (int seg = 0; seg < 5; seg++) begin
         case (seg % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 64;
            end
            default: begin
               send_idle_pct = 14;
               stall_pct = 14;
            end
         endcase
         write_row_pitch(pitches[seg]);
         while (byte_stream.size() < 300) add_picture_record();
         send_stream(seg);
         wait_quiet();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d record bytes across four idle patterns and six row pitch settings.",
               bytes_accepted);
      $display("Checked %0d result items, %0d of them fill runs, with %0d mismatches.",
               results_checked, fills_checked, mismatch_count);
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("planar_rle_span_decoder_core verification clean");
      end else begin
         $display("planar_rle_span_decoder_core verification failed");
      end
      $finish;
   end

endmodule

### planar_rle_span_decoder_core.f
rtl/core/prsd_pkg.sv
rtl/core/planar_rle_span_decoder_core.sv
verif/span_decode_checker.sv
verif/testbench.sv
